@@ design/qse_pkg.sv @@
`default_nettype none

package qse_pkg;

    typedef enum logic [4:0] {
        S_LOAD,
        S_SORT_START,
        S_POP,
        S_POP_WAIT,
        S_PIVOT,
        S_I_INC,
        S_I_CMP,
        S_K_DEC,
        S_K_CMP,
        S_DECIDE,
        S_SWAP_I,
        S_SWAP_K,
        S_FIN_RD,
        S_FIN_LO,
        S_FIN_K,
        S_PUSH_LO,
        S_PUSH_HI,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

`default_nettype wire

@@ design/qse_ram.sv @@
`default_nettype none

module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/quicksort_engine_top.sv @@
`default_nettype none

// loading takes one item per cycle; the store has one read and one write port
// sorting: all element reads go through the single store read port
// emission reads each result from the store, then loads it into the output register
// while the output is free; no item is taken from the last transfer
// until the final result is in the output register
// reset clears the state, count, range stack pointer, indices, overflow flag and output valid

module quicksort_engine_top #(
    parameter int MAX_ELEMENTS = 16,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          last,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed      [VALUE_WIDTH-1:0] sorted_value,
    output logic                               last_out,
    output logic                               overflow
);

    import qse_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS + 2);
    localparam int VW = VALUE_WIDTH;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] j_reg, j_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] k_reg, k_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [VW-1:0] pivot_reg, pivot_next;
    logic [VW-1:0] ai_reg, ai_next;
    logic [VW-1:0] ak_reg, ak_next;

    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    // element store
    logic          st_wr_en, st_rd_en;
    logic [AW-1:0] st_wr_addr, st_rd_addr;
    logic [VW-1:0] st_wr_data, st_rd_data;

    // range stack, entries are {lo, hi}
    logic            rs_wr_en, rs_rd_en;
    logic [AW-1:0]   rs_wr_addr, rs_rd_addr;
    logic [2*AW-1:0] rs_wr_data, rs_rd_data;

    logic [IW-1:0] ni, nk;
    logic [CW-1:0] count_inc;
    logic          out_free;

    qse_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    qse_ram #(
        .WIDTH (2 * AW),
        .DEPTH (MAX_ELEMENTS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (rs_wr_en),
        .wr_addr (rs_wr_addr),
        .wr_data (rs_wr_data),
        .rd_en   (rs_rd_en),
        .rd_addr (rs_rd_addr),
        .rd_data (rs_rd_data)
    );

    assign ni        = i_reg + IW'(1);
    assign nk        = k_reg - IW'(1);
    assign count_inc = count_reg + CW'(1);
    assign out_free  = !out_valid_reg || !result_stall;

    assign item_stall   = (state_reg != S_LOAD);
    assign result_valid = out_valid_reg;
    assign sorted_value = $signed(out_value_reg);
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        pivot_reg     <= pivot_next;
        ai_reg        <= ai_next;
        ak_reg        <= ak_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        j_next         = j_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pivot_next     = pivot_reg;
        ai_next        = ai_reg;
        ak_next        = ak_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        st_wr_en   = 1'b0;
        st_wr_addr = '0;
        st_wr_data = '0;
        st_rd_en   = 1'b0;
        st_rd_addr = '0;
        rs_wr_en   = 1'b0;
        rs_wr_addr = '0;
        rs_wr_data = '0;
        rs_rd_en   = 1'b0;
        rs_rd_addr = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < CW'(MAX_ELEMENTS))
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = count_reg[AW-1:0];
                        st_wr_data = value;
                        count_next = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        j_next = '0;
                        if (count_next < CW'(2))
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            state_next = S_SORT_START;
                        end
                    end
                end
            end

            S_SORT_START:
            begin
                rs_wr_en   = 1'b1;
                rs_wr_addr = '0;
                rs_wr_data = {AW'(0), AW'(count_reg - CW'(1))};
                sp_next    = CW'(1);
                state_next = S_POP;
            end

            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    j_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    rs_rd_en   = 1'b1;
                    rs_rd_addr = AW'(sp_reg - CW'(1));
                    sp_next    = sp_reg - CW'(1);
                    state_next = S_POP_WAIT;
                end
            end

            S_POP_WAIT:
            begin
                lo_next    = rs_rd_data[2*AW-1:AW];
                hi_next    = rs_rd_data[AW-1:0];
                st_rd_en   = 1'b1;
                st_rd_addr = rs_rd_data[2*AW-1:AW];
                state_next = S_PIVOT;
            end

            S_PIVOT:
            begin
                pivot_next = st_rd_data;
                i_next     = IW'(lo_reg);
                k_next     = IW'(hi_reg) + IW'(1);
                state_next = S_I_INC;
            end

            // left scan, bounded by the top of the range and by k
            S_I_INC:
            begin
                i_next = ni;
                if (ni <= IW'(hi_reg) && ni <= k_reg)
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = ni[AW-1:0];
                    state_next = S_I_CMP;
                end
                else
                begin
                    state_next = S_K_DEC;
                end
            end

            S_I_CMP:
            begin
                if ($signed(st_rd_data) < $signed(pivot_reg))
                begin
                    i_next = ni;
                    if (ni <= IW'(hi_reg) && ni <= k_reg)
                    begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = ni[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_K_DEC;
                    end
                end
                else
                begin
                    ai_next    = st_rd_data;
                    state_next = S_K_DEC;
                end
            end

            // right scan
            S_K_DEC:
            begin
                k_next = nk;
                if (i_reg <= nk)
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = nk[AW-1:0];
                    state_next = S_K_CMP;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end

            S_K_CMP:
            begin
                if ($signed(pivot_reg) < $signed(st_rd_data))
                begin
                    k_next = nk;
                    if (i_reg <= nk)
                    begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = nk[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    ak_next    = st_rd_data;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (i_reg < k_reg)
                begin
                    state_next = S_SWAP_I;
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end

            S_SWAP_I:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = i_reg[AW-1:0];
                st_wr_data = ak_reg;
                state_next = S_SWAP_K;
            end

            S_SWAP_K:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = k_reg[AW-1:0];
                st_wr_data = ai_reg;
                state_next = S_I_INC;
            end

            // pivot goes to its final place at k
            S_FIN_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = k_reg[AW-1:0];
                state_next = S_FIN_LO;
            end

            S_FIN_LO:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = lo_reg;
                st_wr_data = st_rd_data;
                state_next = S_FIN_K;
            end

            S_FIN_K:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = k_reg[AW-1:0];
                st_wr_data = pivot_reg;
                state_next = S_PUSH_LO;
            end

            S_PUSH_LO:
            begin
                if (IW'(lo_reg) + IW'(1) < k_reg && sp_reg < CW'(MAX_ELEMENTS))
                begin
                    rs_wr_en   = 1'b1;
                    rs_wr_addr = sp_reg[AW-1:0];
                    rs_wr_data = {lo_reg, AW'(nk)};
                    sp_next    = sp_reg + CW'(1);
                end
                state_next = S_PUSH_HI;
            end

            S_PUSH_HI:
            begin
                if (ni > k_reg && k_reg + IW'(1) < IW'(hi_reg)
                    && sp_reg < CW'(MAX_ELEMENTS))
                begin
                    rs_wr_en   = 1'b1;
                    rs_wr_addr = sp_reg[AW-1:0];
                    rs_wr_data = {AW'(k_reg + IW'(1)), hi_reg};
                    sp_next    = sp_reg + CW'(1);
                end
                state_next = S_POP;
            end

            S_EMIT_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = j_reg[AW-1:0];
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = st_rd_data;
                    out_last_next  = (j_reg + CW'(1) == count_reg);
                    out_ovf_next   = ovf_reg;
                    j_next         = j_reg + CW'(1);
                    if (j_reg + CW'(1) == count_reg)
                    begin
                        count_next = '0;
                        sp_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire
